@@ hdl/two_class_burst_round_robin_macros.svh @@
// Assertion helpers for the checker file.
`ifndef TWO_CLASS_BURST_ROUND_ROBIN_MACROS_SVH
`define TWO_CLASS_BURST_ROUND_ROBIN_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TCBRR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TCBRR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hdl/tcbrr_pkg.sv @@
package tcbrr_pkg;

   // Field widths of the request and response words.
   localparam int ACTION_W        = 1;
   localparam int TASK_SLOT_W     = 3;
   localparam int GRANTED_SLOT_W  = 3;
   localparam int DESC_W          = 13;
   localparam int BURST_W         = 4;

   // Configuration port shape.
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 13;

   // Default slot count and reset values.
   localparam int NUM_SLOTS_DEFAULT        = 8;
   localparam int MAIN_BURST_LENGTH_RESET  = 4;

   // Wide enough to hold any slot index plus one full turn (up to 128 slots).
   localparam int IDX_CMP_W       = 8;

   typedef enum logic [ACTION_W-1:0] {
      ACTION_PICK  = 1'b0,
      ACTION_EVICT = 1'b1
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAIN_BURST_LENGTH         = 2'd0,
      CSR_MAIN_DESCRIPTOR_BASE      = 2'd1,
      CSR_COMPANION_DESCRIPTOR_BASE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_pick;
   } dp_status_type;

endpackage

@@ hdl/tcbrr_req_if.sv @@
interface tcbrr_req_if import tcbrr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [ACTION_W-1:0]    action;
   logic [TASK_SLOT_W-1:0] task_slot;

   modport source (output valid, output action, output task_slot, input ready);
   modport sink   (input valid, input action, input task_slot, output ready);
   modport monitor (input valid, input ready, input action, input task_slot);
endinterface

@@ hdl/tcbrr_rsp_if.sv @@
interface tcbrr_rsp_if import tcbrr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      granted;
   logic                      granted_class;
   logic [GRANTED_SLOT_W-1:0] granted_slot;
   logic [DESC_W-1:0]         descriptor_index;

   modport source (output valid, output granted, output granted_class,
                   output granted_slot, output descriptor_index, input ready);
   modport sink   (input valid, input granted, input granted_class,
                   input granted_slot, input descriptor_index, output ready);
   modport monitor (input valid, input ready, input granted, input granted_class,
                    input granted_slot, input descriptor_index);
endinterface

@@ hdl/tcbrr_datapath.sv @@
module tcbrr_datapath import tcbrr_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_cmd_type              cmd,
   output dp_status_type             status,
   input  logic [ACTION_W-1:0]       req_action,
   input  logic [TASK_SLOT_W-1:0]    req_task_slot,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data,
   output logic                      rsp_granted,
   output logic                      rsp_granted_class,
   output logic [GRANTED_SLOT_W-1:0] rsp_granted_slot,
   output logic [DESC_W-1:0]         rsp_descriptor_index
);

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

   // Configuration registers.
   logic [BURST_W-1:0] main_burst_length_ff;
   logic [DESC_W-1:0]  main_base_ff;
   logic [DESC_W-1:0]  companion_base_ff;

   // Scheduler state.
   logic [NUM_SLOTS-1:0] live_mask_ff, live_mask_in;
   logic [CNT_W-1:0]     live_count_ff, live_count_in;
   logic [SLOT_W-1:0]    main_last_ff, main_last_in;
   logic [SLOT_W-1:0]    companion_last_ff, companion_last_in;
   logic [BURST_W-1:0]   main_remaining_ff, main_remaining_in;
   logic [CNT_W-1:0]     companion_remaining_ff, companion_remaining_in;

   // Captured request word.
   logic [ACTION_W-1:0]    action_ff;
   logic [TASK_SLOT_W-1:0] task_slot_ff;

   // Result word.
   logic                      granted_ff, granted_in;
   logic                      class_ff, class_in;
   logic [GRANTED_SLOT_W-1:0] slot_ff, slot_in;
   logic [DESC_W-1:0]         desc_ff, desc_in;

   logic               main_phase;
   logic               companion_phase;
   logic [SLOT_W-1:0]  search_last;
   logic               found;
   logic [SLOT_W-1:0]  found_slot;
   logic [IDX_CMP_W-1:0] evict_ext;
   logic [SLOT_W-1:0]  evict_idx;
   logic               evict_hit;
   logic [BURST_W-1:0] burst_reload;

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_burst_length_ff <= BURST_W'(MAIN_BURST_LENGTH_RESET);
         main_base_ff         <= '0;
         companion_base_ff    <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MAIN_BURST_LENGTH:         main_burst_length_ff <= csr_write_data[BURST_W-1:0];
            CSR_MAIN_DESCRIPTOR_BASE:      main_base_ff         <= csr_write_data[DESC_W-1:0];
            CSR_COMPANION_DESCRIPTOR_BASE: companion_base_ff    <= csr_write_data[DESC_W-1:0];
            default: ;
         endcase
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff    <= req_action;
         task_slot_ff <= req_task_slot;
      end
   end

   assign status.is_pick = (action_ff == ACTION_PICK);

   // The active phase picks which round-robin pointer drives the search.
   assign main_phase      = (main_remaining_ff != '0);
   assign companion_phase = (companion_remaining_ff != '0);
   assign search_last     = main_phase ? main_last_ff : companion_last_ff;

   // Rotating priority encoder: first live slot after the pointer.
   always_comb begin
      logic [IDX_CMP_W-1:0] cand;
      found      = 1'b0;
      found_slot = '0;
      for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
         cand = IDX_CMP_W'(search_last) + IDX_CMP_W'(k + 1);
         if (cand >= IDX_CMP_W'(NUM_SLOTS)) begin
            cand = cand - IDX_CMP_W'(NUM_SLOTS);
         end
         if (live_mask_ff[cand[SLOT_W-1:0]]) begin
            found      = 1'b1;
            found_slot = cand[SLOT_W-1:0];
         end
      end
   end

   // Eviction target; slots beyond the slot count are ignored.
   assign evict_ext = IDX_CMP_W'(task_slot_ff);
   assign evict_idx = evict_ext[SLOT_W-1:0];
   assign evict_hit = (evict_ext < IDX_CMP_W'(NUM_SLOTS)) && live_mask_ff[evict_idx];

   // A zero burst length reloads as one.
   assign burst_reload = (main_burst_length_ff == '0) ? BURST_W'(1) : main_burst_length_ff;

   // Next-state and result logic for one executed word.
   always_comb begin
      live_mask_in           = live_mask_ff;
      live_count_in          = live_count_ff;
      main_last_in           = main_last_ff;
      companion_last_in      = companion_last_ff;
      main_remaining_in      = main_remaining_ff;
      companion_remaining_in = companion_remaining_ff;
      granted_in             = granted_ff;
      class_in               = class_ff;
      slot_in                = slot_ff;
      desc_in                = desc_ff;
      if (cmd.execute) begin
         if (!status.is_pick) begin
            if (evict_hit) begin
               live_mask_in[evict_idx] = 1'b0;
               live_count_in           = live_count_ff - CNT_W'(1);
            end
         end else begin
            granted_in = 1'b0;
            class_in   = 1'b0;
            slot_in    = '0;
            desc_in    = '0;
            if (main_phase && found) begin
               main_last_in      = found_slot;
               main_remaining_in = main_remaining_ff - BURST_W'(1);
               if (main_remaining_ff == BURST_W'(1)) begin
                  companion_remaining_in = live_count_ff;
               end
               granted_in = 1'b1;
               slot_in    = GRANTED_SLOT_W'(IDX_CMP_W'(found_slot));
               desc_in    = main_base_ff + DESC_W'(found_slot);
            end else if (!main_phase && companion_phase && found) begin
               companion_last_in      = found_slot;
               companion_remaining_in = companion_remaining_ff - CNT_W'(1);
               if (companion_remaining_ff == CNT_W'(1)) begin
                  main_remaining_in = burst_reload;
               end
               granted_in = 1'b1;
               class_in   = 1'b1;
               slot_in    = GRANTED_SLOT_W'(IDX_CMP_W'(found_slot));
               desc_in    = companion_base_ff + DESC_W'(found_slot);
            end
         end
      end
   end

   // Scheduler state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         live_mask_ff           <= '1;
         live_count_ff          <= CNT_W'(NUM_SLOTS);
         main_last_ff           <= SLOT_W'(NUM_SLOTS - 1);
         companion_last_ff      <= SLOT_W'(NUM_SLOTS - 1);
         main_remaining_ff      <= BURST_W'(MAIN_BURST_LENGTH_RESET);
         companion_remaining_ff <= '0;
      end else begin
         live_mask_ff           <= live_mask_in;
         live_count_ff          <= live_count_in;
         main_last_ff           <= main_last_in;
         companion_last_ff      <= companion_last_in;
         main_remaining_ff      <= main_remaining_in;
         companion_remaining_ff <= companion_remaining_in;
      end
   end

   // Result word register.
   always_ff @(posedge clock) begin
      granted_ff <= granted_in;
      class_ff   <= class_in;
      slot_ff    <= slot_in;
      desc_ff    <= desc_in;
   end

   assign rsp_granted          = granted_ff;
   assign rsp_granted_class    = class_ff;
   assign rsp_granted_slot     = slot_ff;
   assign rsp_descriptor_index = desc_ff;

endmodule

@@ hdl/tcbrr_controller.sv @@
module tcbrr_controller import tcbrr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and handshake outputs.
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = status.is_pick ? ST_RESP : ST_IDLE;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ hdl/two_class_burst_round_robin.sv @@
// Two-class burst round-robin task scheduler.
// The req channel carries one word per operation: action pick or evict, and
// task_slot for an evict. Every pick returns one word on the rsp channel with
// granted, granted_class, granted_slot and descriptor_index; an evict returns
// nothing. The csr port writes burst length and the two descriptor bases
// whenever csr_write_enable is high; write only while no operation is open.
// One word is in flight at a time. A pick is accepted in the idle state,
// decided in the next cycle by a single rotating priority encoder over the
// live mask, and its response is valid from the cycle after that; an evict
// is executed in the execute state and returns to idle with no response.
// The response stays in its output register while rsp.ready is low; no new
// request is taken until it has been delivered.
// Synchronous reset marks every slot live, points both round-robin pointers
// at the last slot, loads a main burst of four and restores the registers to
// their defaults. No clearing pass is needed after reset.
module two_class_burst_round_robin import tcbrr_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   tcbrr_req_if.sink              req,
   tcbrr_rsp_if.source            rsp,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencing and handshakes.
   tcbrr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Scheduler state, search and result word.
   tcbrr_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_action           (req.action),
      .req_task_slot        (req.task_slot),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .rsp_granted          (rsp.granted),
      .rsp_granted_class    (rsp.granted_class),
      .rsp_granted_slot     (rsp.granted_slot),
      .rsp_descriptor_index (rsp.descriptor_index)
   );

endmodule

@@ hdl/tcbrr_checker.sv @@
`include "two_class_burst_round_robin_macros.svh"

module tcbrr_checker import tcbrr_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_granted,
   input logic                      rsp_granted_class,
   input logic [GRANTED_SLOT_W-1:0] rsp_granted_slot,
   input logic [DESC_W-1:0]         rsp_descriptor_index
);

   logic                             req_fire;
   logic                             rsp_stall;
   logic                             rsp_fields_zero;
   logic [GRANTED_SLOT_W+DESC_W+1:0] rsp_word;

   assign req_fire        = req_valid && req_ready;
   assign rsp_stall       = rsp_valid && !rsp_ready;
   assign rsp_fields_zero = !rsp_granted_class && (rsp_granted_slot == '0) &&
                            (rsp_descriptor_index == '0);
   assign rsp_word        = {rsp_granted, rsp_granted_class, rsp_granted_slot,
                             rsp_descriptor_index};

   // A word without a grant carries all-zero fields.
   `TCBRR_ASSERT_IMPL(a_none_is_zero, clock, reset, rsp_valid && !rsp_granted, rsp_fields_zero)

   // Only one word is in flight: nothing is accepted while a response waits.
   `TCBRR_ASSERT_IMPL(a_single_flight, clock, reset, rsp_valid, !req_ready)

   // An accepted request is decided before any response shows.
   `TCBRR_ASSERT_NEXT(a_decide_cycle, clock, reset, req_fire, !rsp_valid && !req_ready)

   // A stalled response holds its word.
   `TCBRR_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))

endmodule

bind two_class_burst_round_robin tcbrr_checker u_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req.valid),
   .req_ready            (req.ready),
   .rsp_valid            (rsp.valid),
   .rsp_ready            (rsp.ready),
   .rsp_granted          (rsp.granted),
   .rsp_granted_class    (rsp.granted_class),
   .rsp_granted_slot     (rsp.granted_slot),
   .rsp_descriptor_index (rsp.descriptor_index)
);
